// File: rtl/core/hts_pkg.sv
// Package: codes, constants, result word type and helpers of the humidity/temperature reader
`default_nettype none
package hts_pkg;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 88;
    localparam int CFG_DATA_W = 10;
    localparam int QDEPTH = 4;
    localparam int FRAME_BYTES = 5;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_CALIB    = 3'd1,
        ACT_MEASURE  = 3'd2,
        ACT_WR_DONE  = 3'd3,
        ACT_RD_BYTE  = 3'd4
    } t_action;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WR_FAIL   = 3'd1;
    localparam logic [2:0] ST_RD_FAIL   = 3'd2;
    localparam logic [2:0] ST_TIMEOUT   = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;
    localparam logic [2:0] ST_NOT_CALIB = 3'd5;

    localparam logic [1:0] CFG_CAL_WAIT  = 2'd0;
    localparam logic [1:0] CFG_MEAS_WAIT = 2'd1;
    localparam logic [1:0] CFG_POLL_LIM  = 2'd2;
    localparam logic [1:0] CFG_POLL_INT  = 2'd3;

    localparam logic [9:0] RST_CAL_WAIT  = 10'd40;
    localparam logic [9:0] RST_MEAS_WAIT = 10'd80;
    localparam logic [7:0] RST_POLL_LIM  = 8'd100;
    localparam logic [7:0] RST_POLL_INT  = 8'd1;

    localparam logic [7:0] CMD_CALIB   = 8'hE1;
    localparam logic [7:0] CMD_CAL_ARG = 8'h08;
    localparam logic [7:0] CMD_MEASURE = 8'hAC;
    localparam logic [7:0] CMD_MEAS_ARG = 8'h33;
    localparam logic [7:0] CMD_ZERO    = 8'h00;

    localparam logic [2:0] RD_LEN_STATUS = 3'd1;
    localparam logic [2:0] RD_LEN_FRAME  = 3'd6;

    localparam logic [13:0] HUM_SCALE  = 14'd10000;
    localparam logic [14:0] TEMP_SCALE = 15'd20000;
    localparam logic signed [14:0] TEMP_OFFSET = 15'sd5000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         write_byte;
        logic [2:0]         read_length;
        logic               last;
        logic [2:0]         status;
        logic [13:0]        humidity_centi;
        logic signed [14:0] temperature_centi;
        logic [19:0]        raw_humidity;
        logic [19:0]        raw_temperature;
    } t_result;

    function automatic t_result f_write(input logic [7:0] b, input logic lst);
        t_result r;
        r = '0;
        r.kind = KIND_WRITE;
        r.write_byte = b;
        r.last = lst;
        return r;
    endfunction

    function automatic t_result f_read(input logic [2:0] len);
        t_result r;
        r = '0;
        r.kind = KIND_READ;
        r.read_length = len;
        return r;
    endfunction

    function automatic t_result f_report(input logic [2:0] st);
        t_result r;
        r = '0;
        r.kind = KIND_REPORT;
        r.status = st;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/humidity_temperature_sensor_reader_core.sv
// Top level: event sequencer for the humidity/temperature sensor with result word queue
// Result words caused by an accepted event word are registered into the queue and offered in order.
// Throughput: one event word per cycle while the four-entry result queue holds at most
// one word; a command request queues three write words, drained one per cycle while i_m_tready is high.
// Reset: synchronous active low; phase idle, counters zero, registers to defaults,
// queue empty. Frame bytes are not reset.
`default_nettype none
module humidity_temperature_sensor_reader_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [hts_pkg::S_TDATA_W-1:0]  i_s_tdata,   // bus_error, read_byte[7:0]
    input  wire logic [2:0]                     i_s_tuser,   // action
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [hts_pkg::M_TDATA_W-1:0]       o_m_tdata,   // write_byte, read_length,
                                                             // status, humidity_centi,
                                                             // temperature_centi,
                                                             // raw_humidity, raw_temperature
    output logic [1:0]                          o_m_tuser,   // kind
    output logic                                o_m_tlast,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [hts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hts_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_CMD_WRITE, PH_CMD_WAIT, PH_STATUS_READ,
        PH_POLL_READ, PH_POLL_WAIT, PH_DATA_READ
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_doing_measure, n_doing_measure;
    logic [9:0]  r_wait_count, n_wait_count;
    logic [7:0]  r_poll_count, n_poll_count;
    logic [2:0]  r_byte_index, n_byte_index;
    logic [9:0]  r_cal_wait, r_meas_wait;
    logic [7:0]  r_poll_limit, r_poll_int;
    logic [7:0]  r_frame [FRAME_BYTES];

    t_result     r_q [QDEPTH];
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_count;

    logic        w_accept, w_pop, w_frame_we;
    t_action     w_action;
    logic        w_err;
    logic [7:0]  w_rb;
    t_result     w_res [3];
    logic [1:0]  w_nres;
    logic        v_wait_done, v_poll;
    logic [7:0]  v_pc;
    logic [9:0]  v_wc;

    logic [19:0] w_rh, w_rt;
    logic [33:0] w_hprod;
    logic [34:0] w_tprod;
    t_result     w_meas;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_pop    = o_m_tvalid && i_m_tready;
    assign w_action = t_action'(i_s_tuser);
    assign w_err    = i_s_tdata[0];
    assign w_rb     = w_err ? 8'h00 : i_s_tdata[8:1];

    assign o_s_tready  = (r_count <= 3'd1);
    assign o_m_tvalid  = (r_count != 3'd0);
    assign o_cfg_ready = 1'b1;

    // frame unpack and scaling to hundredths
    assign w_rh    = {r_frame[1], r_frame[2], r_frame[3][7:4]};
    assign w_rt    = {r_frame[3][3:0], r_frame[4], w_rb};
    assign w_hprod = 34'(w_rh) * 34'(HUM_SCALE);
    assign w_tprod = 35'(w_rt) * 35'(TEMP_SCALE);

    always_comb begin
        w_meas = f_report(ST_OK);
        w_meas.humidity_centi    = w_hprod[33:20];
        w_meas.temperature_centi = signed'(w_tprod[34:20]) - TEMP_OFFSET;
        w_meas.raw_humidity      = w_rh;
        w_meas.raw_temperature   = w_rt;
    end

    always_comb begin
        n_phase         = r_phase;
        n_doing_measure = r_doing_measure;
        n_wait_count    = r_wait_count;
        n_poll_count    = r_poll_count;
        n_byte_index    = r_byte_index;
        w_frame_we      = 1'b0;
        w_res[0]        = '0;
        w_res[1]        = '0;
        w_res[2]        = '0;
        w_nres          = 2'd0;
        v_wait_done     = 1'b0;
        v_poll          = 1'b0;
        v_pc            = r_poll_count;
        v_wc            = r_wait_count;

        unique case (w_action)
            ACT_TICK: begin
                if (r_phase == PH_CMD_WAIT || r_phase == PH_POLL_WAIT) begin
                    v_wc = (r_wait_count != 10'd0) ? r_wait_count - 10'd1 : 10'd0;
                    n_wait_count = v_wc;
                    if (v_wc == 10'd0) begin
                        if (r_phase == PH_CMD_WAIT) begin
                            v_wait_done = 1'b1;
                        end else begin
                            v_poll = 1'b1;
                        end
                    end
                end
            end
            ACT_CALIB, ACT_MEASURE: begin
                if (r_phase == PH_IDLE) begin
                    n_doing_measure = (w_action == ACT_MEASURE);
                    n_phase  = PH_CMD_WRITE;
                    w_res[0] = f_write((w_action == ACT_MEASURE) ? CMD_MEASURE : CMD_CALIB,
                                       1'b0);
                    w_res[1] = f_write((w_action == ACT_MEASURE) ? CMD_MEAS_ARG : CMD_CAL_ARG,
                                       1'b0);
                    w_res[2] = f_write(CMD_ZERO, 1'b1);
                    w_nres   = 2'd3;
                end
            end
            ACT_WR_DONE: begin
                if (r_phase == PH_CMD_WRITE) begin
                    if (w_err) begin
                        n_phase  = PH_IDLE;
                        w_res[0] = f_report(ST_WR_FAIL);
                        w_nres   = 2'd1;
                    end else begin
                        v_wc = r_doing_measure ? r_meas_wait : r_cal_wait;
                        n_wait_count = v_wc;
                        if (v_wc == 10'd0) begin
                            v_wait_done = 1'b1;
                        end else begin
                            n_phase = PH_CMD_WAIT;
                        end
                    end
                end
            end
            ACT_RD_BYTE: begin
                unique case (r_phase)
                    PH_STATUS_READ: begin
                        n_phase  = PH_IDLE;
                        w_res[0] = f_report(w_rb[3] ? ST_OK : ST_NOT_CALIB);
                        w_nres   = 2'd1;
                    end
                    PH_POLL_READ: begin
                        if (!w_rb[7]) begin
                            n_phase      = PH_DATA_READ;
                            n_byte_index = 3'd0;
                            w_res[0]     = f_read(RD_LEN_FRAME);
                            w_nres       = 2'd1;
                        end else begin
                            v_pc = (r_poll_count != 8'hFF) ? r_poll_count + 8'd1 : r_poll_count;
                            n_poll_count = v_pc;
                            if (r_poll_int == 8'd0) begin
                                v_poll = 1'b1;
                            end else begin
                                n_wait_count = 10'(r_poll_int);
                                n_phase      = PH_POLL_WAIT;
                            end
                        end
                    end
                    PH_DATA_READ: begin
                        if (w_err) begin
                            n_phase  = PH_IDLE;
                            w_res[0] = f_report(ST_RD_FAIL);
                            w_nres   = 2'd1;
                        end else if (r_byte_index < 3'(FRAME_BYTES)) begin
                            w_frame_we   = 1'b1;
                            n_byte_index = r_byte_index + 3'd1;
                        end else if (r_frame[0][7]) begin
                            n_phase  = PH_IDLE;
                            w_res[0] = f_report(ST_BUSY);
                            w_nres   = 2'd1;
                        end else begin
                            n_phase  = PH_IDLE;
                            w_res[0] = w_meas;
                            w_nres   = 2'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (v_wait_done) begin
            if (r_doing_measure) begin
                v_pc         = 8'd0;
                n_poll_count = 8'd0;
                v_poll       = 1'b1;
            end else begin
                n_phase  = PH_STATUS_READ;
                w_res[0] = f_read(RD_LEN_STATUS);
                w_nres   = 2'd1;
            end
        end

        if (v_poll) begin
            if (v_pc >= r_poll_limit) begin
                n_phase  = PH_IDLE;
                w_res[0] = f_report(ST_TIMEOUT);
            end else begin
                n_phase  = PH_POLL_READ;
                w_res[0] = f_read(RD_LEN_STATUS);
            end
            w_nres = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_doing_measure <= 1'b0;
            r_wait_count    <= '0;
            r_poll_count    <= '0;
            r_byte_index    <= '0;
            r_cal_wait      <= RST_CAL_WAIT;
            r_meas_wait     <= RST_MEAS_WAIT;
            r_poll_limit    <= RST_POLL_LIM;
            r_poll_int      <= RST_POLL_INT;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            if (w_accept) begin
                r_phase         <= n_phase;
                r_doing_measure <= n_doing_measure;
                r_wait_count    <= n_wait_count;
                r_poll_count    <= n_poll_count;
                r_byte_index    <= n_byte_index;
                r_wr_ptr        <= r_wr_ptr + w_nres;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (w_accept ? 3'(w_nres) : 3'd0) - (w_pop ? 3'd1 : 3'd0);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_CAL_WAIT:  r_cal_wait   <= i_cfg_data;
                    CFG_MEAS_WAIT: r_meas_wait  <= i_cfg_data;
                    CFG_POLL_LIM:  r_poll_limit <= i_cfg_data[7:0];
                    CFG_POLL_INT:  r_poll_int   <= i_cfg_data[7:0];
                endcase
            end
        end
    end

    // payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept && w_frame_we) begin
            r_frame[r_byte_index] <= w_rb;
        end
        if (w_accept) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < w_nres) begin
                    r_q[r_wr_ptr + 2'(k)] <= w_res[k];
                end
            end
        end
    end

    assign o_m_tuser = r_q[r_rd_ptr].kind;
    assign o_m_tlast = r_q[r_rd_ptr].last;
    assign o_m_tdata = {5'b0,
                        r_q[r_rd_ptr].raw_temperature,
                        r_q[r_rd_ptr].raw_humidity,
                        r_q[r_rd_ptr].temperature_centi,
                        r_q[r_rd_ptr].humidity_centi,
                        r_q[r_rd_ptr].status,
                        r_q[r_rd_ptr].read_length,
                        r_q[r_rd_ptr].write_byte};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(QDEPTH))
        else $error("result queue overfilled");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_accept) |=> (r_count == $past(r_count) - 3'd1))
        else $error("queue count not reduced on pop");

    a_byte_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= 3'(FRAME_BYTES))
        else $error("frame byte index out of range");

    a_wait_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CMD_WAIT || r_phase == PH_POLL_WAIT) |-> (r_wait_count != 10'd0))
        else $error("waiting with an expired count");

endmodule
`default_nettype wire
